>>> rtl/core/fwr_pkg.sv
// shared codes, defaults and result struct of the fifo with remove by value
`timescale 1ns / 1ps

package fwr_pkg;

    localparam int FWR_DEPTH = 16;
    localparam int VALUE_W   = 32;

    // action codes
    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_POP    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EMPTY     = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } fwr_resp_t;

endpackage

>>> rtl/core/fwr_core.sv
// queue storage, scan sequencer and compare unit of the fifo with remove by value
`timescale 1ns / 1ps

module fwr_core import fwr_pkg::*; #(
    parameter  int DEPTH = FWR_DEPTH,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [1:0]         action,
    input  logic [VALUE_W-1:0] value,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_ready,
    output fwr_resp_t          resp,
    output logic [CW-1:0]      count
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_POP_WAIT = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_RESP     = 3'd3;

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [2:0]         state_reg, state_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [CW-1:0]      rd_off_reg, rd_off_next;
    logic [CW-1:0]      cmp_off_reg, cmp_off_next;
    logic [CW-1:0]      kept_reg, kept_next;
    fwr_resp_t          resp_reg, resp_next;
    logic [VALUE_W-1:0] rd_data_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               match;
    logic [CW-1:0]      kept_inc;

    // physical slot of a queue offset from the head
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, off};
        if (s >= (CW + 1)'(DEPTH)) s = s - (CW + 1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    assign match    = (rd_data_reg == val_reg);
    assign kept_inc = match ? kept_reg : kept_reg + CW'(1);

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        val_next     = val_reg;
        rd_off_next  = rd_off_reg;
        cmp_off_next = cmp_off_reg;
        kept_next    = kept_reg;
        resp_next    = resp_reg;
        mem_we       = 1'b0;
        mem_waddr    = slot(head_reg, kept_reg);
        mem_wdata    = rd_data_reg;
        mem_raddr    = head_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    val_next  = value;
                    resp_next = '{value: '0, status: STAT_OK};
                    case (action)
                        ACT_PUSH: begin
                            if (count_reg == CW'(DEPTH)) begin
                                resp_next.status = STAT_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = slot(head_reg, count_reg);
                                mem_wdata  = value;
                                count_next = count_reg + CW'(1);
                            end
                            state_next = S_RESP;
                        end
                        ACT_POP: begin
                            if (count_reg == '0) begin
                                resp_next  = '{value: '1, status: STAT_EMPTY};
                                state_next = S_RESP;
                            end else begin
                                state_next = S_POP_WAIT;
                            end
                        end
                        ACT_REMOVE: begin
                            if (count_reg == '0) begin
                                resp_next.status = STAT_EMPTY;
                                state_next       = S_RESP;
                            end else begin
                                // head read is already in flight
                                rd_off_next  = CW'(1);
                                cmp_off_next = '0;
                                kept_next    = '0;
                                state_next   = S_SCAN;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_POP_WAIT: begin
                resp_next  = '{value: rd_data_reg, status: STAT_OK};
                head_next  = slot(head_reg, CW'(1));
                count_next = count_reg - CW'(1);
                state_next = S_RESP;
            end
            S_SCAN: begin
                mem_raddr    = slot(head_reg, rd_off_reg);
                rd_off_next  = rd_off_reg + CW'(1);
                cmp_off_next = cmp_off_reg + CW'(1);
                if (cmp_off_reg == '0 && match) begin
                    // head holds the value: only the head goes
                    head_next  = slot(head_reg, CW'(1));
                    count_next = count_reg - CW'(1);
                    resp_next  = '{value: val_reg, status: STAT_OK};
                    state_next = S_RESP;
                end else begin
                    // survivors are packed toward the head; writes trail reads
                    mem_we    = !match;
                    kept_next = kept_inc;
                    if (cmp_off_reg == count_reg - CW'(1)) begin
                        if (kept_inc == count_reg) begin
                            resp_next = '{value: '0, status: STAT_NOT_FOUND};
                        end else begin
                            resp_next  = '{value: val_reg, status: STAT_OK};
                            count_next = kept_inc;
                        end
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (res_ready) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        rd_off_reg  <= rd_off_next;
        cmp_off_reg <= cmp_off_next;
        kept_reg    <= kept_next;
        resp_reg    <= resp_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign resp      = resp_reg;
    assign count     = count_reg;

endmodule

>>> rtl/core/fifo_with_remove_by_value_top.sv
// top level of the fifo with remove by value: stream ports and result register
`timescale 1ns / 1ps

// fifo of signed 32-bit values with push, pop and remove by value
// input channel s_axis: one transfer is one action with its value
// result channel m_axis: exactly one result transfer per action, in order
//   result_value, status and the entry count after the action
// from input transfer to m_axis_tvalid: push, the unused code, and pop or
//   remove on an empty queue go straight to the result state; pop waits
//   in its own state for the head read; remove scans the queue, ending at
//   once when the head matches, otherwise comparing every entry; the
//   result then passes through the output register
// the sequencer goes idle as the output register takes its result, and only
// then takes the next input transfer
// remove walks the queue one entry a cycle through the single read port
// of the storage ram, packing survivors through its write port
// one action in flight at a time; s_axis_tready is high only while idle
// the output register lets the next action start while a result waits;
// a stalled receiver holds the result, and the sequencer then waits with
// its own result until the output register frees
// reset empties the queue (head and count cleared); ram contents are
// left as they are and only data read from occupied slots is ever used
module fifo_with_remove_by_value_top import fwr_pkg::*; #(
    parameter  int DEPTH = FWR_DEPTH,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int OUT_W = ((VALUE_W + 2 + CW + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [39:0]      s_axis_tdata,   // action[1:0], value[33:2], zero pad
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // result_value[31:0], status[33:32], count
);

    logic            core_idle;
    logic            core_res_valid;
    logic            core_res_ready;
    fwr_resp_t       core_resp;
    logic [CW-1:0]   core_count;

    logic            m_valid_reg;
    fwr_resp_t       m_resp_reg;
    logic [CW-1:0]   m_count_reg;

    logic            in_xfer;

    assign s_axis_tready = core_idle;
    assign in_xfer       = s_axis_tvalid && core_idle;

    fwr_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (in_xfer),
        .action    (s_axis_tdata[1:0]),
        .value     (s_axis_tdata[33:2]),
        .idle      (core_idle),
        .res_valid (core_res_valid),
        .res_ready (core_res_ready),
        .resp      (core_resp),
        .count     (core_count)
    );

    // output register takes a result when empty or being drained
    assign core_res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_res_ready) begin
            m_valid_reg <= core_res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_res_ready && core_res_valid) begin
            m_resp_reg  <= core_resp;
            m_count_reg <= core_count;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - VALUE_W - 2 - CW){1'b0}}, m_count_reg,
                            m_resp_reg.status, m_resp_reg.value};

    // sequencer is busy right after taking an action
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_axis_tready)
        else $error("input accepted on back-to-back cycles");

    // a refused push only happens with the queue full
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_resp_reg.status == STAT_FULL) |-> (m_count_reg == CW'(DEPTH)))
        else $error("full status with queue not full");

    // an empty status only happens with the queue empty
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_resp_reg.status == STAT_EMPTY) |-> (m_count_reg == '0))
        else $error("empty status with entries in queue");

    // entry count stays within the storage depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        core_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

endmodule

>>> sim/fifo_with_remove_by_value_top_tb.sv
// testbench of the fifo with remove by value: directed and random actions against a queue model
`timescale 1ns / 1ps

module fifo_with_remove_by_value_top_tb;
    import fwr_pkg::*;

    localparam int          CNT_W          = $clog2(FWR_DEPTH + 1);
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          DRAIN_CYCLES   = 2 * FWR_DEPTH + 8;
    // code three is unused by the block and must act as a no-op
    localparam logic [1:0]  ACT_NONE       = 2'd3;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
        logic [CNT_W-1:0]   count;
    } queue_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // action[1:0], value[33:2], zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // result_value[31:0], status[33:32], count[38:34], pad

    // queue model state
    logic [VALUE_W-1:0] model_mem [FWR_DEPTH];
    int                 model_head  = 0;
    int                 model_count = 0;

    queue_result_t pending_results[$];
    int            error_count  = 0;
    int            stall_cycles = 0;
    bit            tx_idle_on   = 1'b1;
    bit            rx_stall_on  = 1'b1;

    fifo_with_remove_by_value_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int slot_at(input int offset);
        return (model_head + offset) % FWR_DEPTH;
    endfunction

    // apply one action to the model and queue the result it must produce
    function automatic void apply_action(input logic [1:0] act, input logic [VALUE_W-1:0] val);
        queue_result_t r;
        bit            found;
        int            kept;
        logic [VALUE_W-1:0] e;
        r.value  = '0;
        r.status = STAT_OK;
        case (act)
            ACT_PUSH: begin
                if (model_count >= FWR_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    model_mem[slot_at(model_count)] = val;
                    model_count++;
                end
            end
            ACT_POP: begin
                if (model_count == 0) begin
                    r.value  = '1;
                    r.status = STAT_EMPTY;
                end else begin
                    r.value    = model_mem[model_head];
                    model_head = (model_head + 1) % FWR_DEPTH;
                    model_count--;
                end
            end
            ACT_REMOVE: begin
                if (model_count == 0) begin
                    r.status = STAT_EMPTY;
                end else if (model_mem[model_head] == val) begin
                    // head match takes out the head only
                    r.value    = val;
                    model_head = (model_head + 1) % FWR_DEPTH;
                    model_count--;
                end else begin
                    found = 1'b0;
                    for (int i = 0; i < model_count; i++) begin
                        if (model_mem[slot_at(i)] == val) found = 1'b1;
                    end
                    if (!found) begin
                        r.status = STAT_NOT_FOUND;
                    end else begin
                        // full pass, survivors packed toward the head in order
                        kept = 0;
                        for (int i = 0; i < model_count; i++) begin
                            e = model_mem[slot_at(i)];
                            if (e != val) begin
                                model_mem[slot_at(kept)] = e;
                                kept++;
                            end
                        end
                        model_count = kept;
                        r.value     = val;
                    end
                end
            end
            default: ;
        endcase
        r.count = model_count[CNT_W-1:0];
        pending_results.push_back(r);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // one input transfer; tvalid stays high into the next call unless a gap is taken
    task automatic send_action(input logic [1:0] act, input logic [VALUE_W-1:0] val);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, val, act};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        apply_action(act, val);
    endtask

    // receiver back-pressure in bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_stall_on && aresetn && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        queue_result_t exp_r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, tdata %h", m_axis_tdata));
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== exp_r.value)
                    report_mismatch($sformatf("result_value %h, expected %h",
                                              m_axis_tdata[31:0], exp_r.value));
                if (m_axis_tdata[33:32] !== exp_r.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tdata[33:32], exp_r.status));
                if (m_axis_tdata[34 +: CNT_W] !== exp_r.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              m_axis_tdata[34 +: CNT_W], exp_r.count));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic test_empty_queue();
        send_action(ACT_POP, 32'h1234_5678);
        send_action(ACT_REMOVE, 32'h0000_0000);
    endtask

    task automatic test_unused_action();
        send_action(ACT_NONE, 32'hffff_ffff);
    endtask

    // fill with extremes and duplicates, then one refused push
    task automatic test_fill_to_full();
        logic [VALUE_W-1:0] fill_vals [FWR_DEPTH];
        fill_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                      32'h0000_0005, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0005,
                      32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0005,
                      32'h8000_0001, 32'h7fff_fffe, 32'h0000_0004, 32'h0000_0006};
        foreach (fill_vals[i]) send_action(ACT_PUSH, fill_vals[i]);
        send_action(ACT_PUSH, 32'h0000_0007);
    endtask

    task automatic test_remove_cases();
        send_action(ACT_REMOVE, 32'h8000_0000);   // head holds the value
        send_action(ACT_REMOVE, 32'h0000_0063);   // absent
        send_action(ACT_REMOVE, 32'h0000_0005);   // several copies inside
    endtask

    task automatic test_pop_order();
        send_action(ACT_POP, 32'h0000_0000);
        send_action(ACT_POP, 32'hdead_beef);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input bit for_remove);
        int roll;
        roll = $urandom_range(0, 99);
        if (for_remove && model_count > 0 && roll < 60)
            return model_mem[slot_at($urandom_range(0, model_count - 1))];
        if (roll < 75)
            return VALUE_W'($urandom_range(0, 5));   // small pool breeds duplicates
        if (roll < 85) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // alternating fill and drain phases so the queue often wraps and hits full or empty
    task automatic test_random_traffic(input int n_items);
        int push_pct;
        int roll;
        push_pct = 70;
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0) push_pct = (push_pct > 50) ? 25 : 75;
            roll = $urandom_range(0, 99);
            if (roll < 3)
                send_action(ACT_NONE, $urandom);
            else if (roll < 3 + push_pct * 97 / 100)
                send_action(ACT_PUSH, pick_value(1'b0));
            else if ($urandom_range(0, 2) == 0)
                send_action(ACT_POP, $urandom);
            else
                send_action(ACT_REMOVE, pick_value(1'b1));
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_unused_action();
        test_fill_to_full();
        test_remove_cases();
        test_pop_order();
        test_random_traffic(1100);

        // closing stretch without idling on either side
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        test_random_traffic(250);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
